[rtl/core/alpm_pkg.sv]
`timescale 1ns / 1ps

package alpm_pkg;

    // Widths of the port fields
    localparam int SAMPLE_W = 12;
    localparam int AMP_W    = 12;
    localparam int REF_W    = 12;
    localparam int LEN_W    = 16;
    localparam int LVL_W    = 7;

    // Converter resolution used inside the datapath
    localparam int SAMPLE_BITS = 12;

    // Dividend amp*100 and the widths around the decay sum
    localparam int NUM_W       = SAMPLE_BITS + LVL_W;
    localparam int DECAY_SHIFT = 5;
    localparam int DEC_W       = SAMPLE_BITS + DECAY_SHIFT;
    localparam int STEP_W      = $clog2(LVL_W);

    localparam logic [LEN_W-1:0]       WIN_LEN_RST    = LEN_W'(64);
    localparam logic [SAMPLE_BITS-1:0] REF_START      = SAMPLE_BITS'(200);
    localparam logic [SAMPLE_BITS-1:0] REF_FLOOR      = SAMPLE_BITS'(10);
    localparam logic [LVL_W-1:0]       FULL_SCALE_PCT = LVL_W'(100);

    // Window tracker status towards the sequencer
    typedef struct packed {
        logic                   close;
        logic [SAMPLE_BITS-1:0] amp;
    } t_win_stat;

    // Divider status towards the sequencer
    typedef struct packed {
        logic             busy;
        logic [LVL_W-1:0] quot;
    } t_div_stat;

endpackage

[rtl/core/alpm_if.sv]
`timescale 1ns / 1ps

// Sample channel
interface alpm_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result channel
interface alpm_result_if;
    logic        valid;
    logic        ready;
    logic [6:0]  level_percent;
    logic [11:0] amplitude;
    logic [11:0] reference;
    modport source (output valid, output level_percent, output amplitude,
                    output reference, input ready);
    modport sink   (input valid, input level_percent, input amplitude,
                    input reference, output ready);
endinterface

// Configuration write channel
interface alpm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] window_length;
    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

[rtl/core/alpm_win.sv]
`timescale 1ns / 1ps

module alpm_win import alpm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [LEN_W-1:0]       i_window_length,
    output t_win_stat              o_stat
);

    logic [SAMPLE_BITS-1:0] r_min, r_max;
    logic [LEN_W-1:0]       r_cnt;
    logic [SAMPLE_BITS-1:0] n_min, n_max;
    logic [LEN_W-1:0]       n_cnt;
    logic [LEN_W-1:0]       w_len;

    // Extremes and count including the offered sample
    always_comb begin
        n_min = (i_sample < r_min) ? i_sample : r_min;
        n_max = (i_sample > r_max) ? i_sample : r_max;
        n_cnt = r_cnt + LEN_W'(1);
        w_len = (i_window_length == '0) ? LEN_W'(1) : i_window_length;
        o_stat.close = (n_cnt >= w_len) || (n_cnt == '0);
        o_stat.amp   = n_max - n_min;
    end

    // Window state: reopen after the closing sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
            r_cnt <= '0;
        end else if (i_take) begin
            if (o_stat.close) begin
                r_min <= '1;
                r_max <= '0;
                r_cnt <= '0;
            end else begin
                r_min <= n_min;
                r_max <= n_max;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

[rtl/core/alpm_div.sv]
`timescale 1ns / 1ps

module alpm_div import alpm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [SAMPLE_BITS-1:0] i_den,
    output t_div_stat              o_stat
);

    logic                   r_busy;
    logic [STEP_W-1:0]      r_step;
    logic [NUM_W-1:0]       r_rem;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [LVL_W-1:0]       r_quot;
    logic [NUM_W:0]         w_den_sh;
    logic [NUM_W:0]         w_diff;
    logic                   w_fit;

    // Shared trial subtract of the shifted divisor
    always_comb begin
        w_den_sh = (NUM_W + 1)'(r_den) << r_step;
        w_diff   = {1'b0, r_rem} - w_den_sh;
        w_fit    = !w_diff[NUM_W];
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(LVL_W - 1);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step - STEP_W'(1);
            end
        end
    end

    // Remainder and quotient, one bit a step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy && w_fit) begin
            r_rem          <= w_diff[NUM_W-1:0];
            r_quot[r_step] <= 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.quot = r_quot;

endmodule

[rtl/core/audio_level_percent_meter_unit.sv]
// Peak-to-peak level meter. Each sample beat updates the window minimum and
// maximum and the block is ready again at once. The sample that completes a
// window of window_length samples (0 counts as 1) yields one result beat: the
// amplitude, the updated peak reference (starts at 200, replaced by a larger
// amplitude, else decays as (ref*31+amp)/32, floored at 10) and the level
// amp*100/ref, capped at 100. That sample keeps the input not ready through
// the reference update, the load of the bit-serial divider, the divider that
// produces one quotient bit a cycle, and the load of the result register,
// which waits while the previous result beat is still not taken. A
// configuration write is taken in any cycle and leaves the window in progress
// as it is.
`timescale 1ns / 1ps

module audio_level_percent_meter_unit import alpm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alpm_sample_if.sink   i_in,
    alpm_result_if.source o_out,
    alpm_cfg_if.sink      i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REF,
        S_LOAD,
        S_DIV
    } t_state;

    t_state                 r_state;
    logic [LEN_W-1:0]       r_wlen;
    logic [SAMPLE_BITS-1:0] r_amp;
    logic [SAMPLE_BITS-1:0] r_peak_ref;
    logic                   r_out_valid;
    logic [LVL_W-1:0]       r_out_lvl;
    logic [SAMPLE_BITS-1:0] r_out_amp;
    logic [SAMPLE_BITS-1:0] r_out_ref;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_div_start;
    t_win_stat              w_win;
    t_div_stat              w_div;
    logic [DEC_W-1:0]       w_dec_sum;
    logic [SAMPLE_BITS-1:0] w_ref_raw;
    logic [SAMPLE_BITS-1:0] n_peak_ref;
    logic [NUM_W-1:0]       w_num;
    logic [LVL_W-1:0]       w_lvl;
    logic                   w_out_load;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    alpm_win u_win (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_accept),
        .i_sample        (i_in.sample[SAMPLE_BITS-1:0]),
        .i_window_length (r_wlen),
        .o_stat          (w_win)
    );

    // Reference update: replace, or decay towards the amplitude, then floor
    always_comb begin
        w_dec_sum  = (DEC_W'(r_peak_ref) << DECAY_SHIFT) - DEC_W'(r_peak_ref)
                   + DEC_W'(r_amp);
        w_ref_raw  = (r_amp > r_peak_ref) ? r_amp
                                          : w_dec_sum[DEC_W-1:DECAY_SHIFT];
        n_peak_ref = (w_ref_raw < REF_FLOOR) ? REF_FLOOR : w_ref_raw;
    end

    // Dividend amp*100 for the divider
    assign w_num       = NUM_W'(r_amp) * NUM_W'(FULL_SCALE_PCT);
    assign w_div_start = (r_state == S_LOAD);

    alpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_peak_ref),
        .o_stat  (w_div)
    );

    assign w_lvl      = (w_div.quot > FULL_SCALE_PCT) ? FULL_SCALE_PCT : w_div.quot;
    assign w_out_load = (r_state == S_DIV) && !w_div.busy && w_out_free;

    // Sequencer, configuration register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wlen      <= WIN_LEN_RST;
            r_amp       <= '0;
            r_peak_ref  <= REF_START;
            r_out_valid <= 1'b0;
            r_out_lvl   <= '0;
            r_out_amp   <= '0;
            r_out_ref   <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_wlen <= i_cfg.window_length;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_lvl   <= w_lvl;
                r_out_amp   <= r_amp;
                r_out_ref   <= r_peak_ref;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_win.close) begin
                        r_amp   <= w_win.amp;
                        r_state <= S_REF;
                    end
                end
                S_REF: begin
                    r_peak_ref <= n_peak_ref;
                    r_state    <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.level_percent = r_out_lvl;
    assign o_out.amplitude     = AMP_W'(r_out_amp);
    assign o_out.reference     = REF_W'(r_out_ref);

    // Divider only runs while the sequencer waits for it
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> (r_state == S_DIV))
        else $error("divider busy outside divide state");

    // Reference never drops below its floor
    a_ref_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak_ref >= REF_FLOOR)
        else $error("peak reference below floor");

    // A result never shows an amplitude above its reference or a level above 100
    a_amp_le_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_amp <= r_out_ref && r_out_lvl <= FULL_SCALE_PCT))
        else $error("result amplitude above reference");

    // A closing sample starts the divider after the reference update state, in the load state
    a_close_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_win.close) |-> ##2 w_div_start)
        else $error("closing sample did not start divider");

endmodule

[tb/audio_level_percent_meter_unit_test.sv]
`timescale 1ns / 1ps

module audio_level_percent_meter_unit_test import alpm_pkg::*; ();

    // Run control
    localparam int CLK_HALF     = 5;
    localparam int SETTLE_CYCLES = 16;   // closing sample keeps the block busy through its divide
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DECAY_KEEP   = 31;

    // Shapes of the sample stream inside one random segment
    typedef enum int {
        FULL_SWING,
        NARROW_BAND,
        FLAT_LINE,
        RAIL_TO_RAIL
    } sample_shape_t;

    // One expected meter reading
    typedef struct {
        logic [LVL_W-1:0] level;
        logic [AMP_W-1:0] amp;
        logic [REF_W-1:0] peak;
    } meter_reading_t;

    // Level meter predictor and reading store
    class level_meter_scoreboard;
        logic [LEN_W-1:0]       window_length;
        logic [SAMPLE_BITS-1:0] win_lo;
        logic [SAMPLE_BITS-1:0] win_hi;
        logic [LEN_W-1:0]       taken;
        logic [SAMPLE_BITS-1:0] peak_ref;
        meter_reading_t         expected_readings[$];
        int                     errors;

        function new();
            window_length = WIN_LEN_RST;
            peak_ref      = REF_START;
            win_lo        = '1;
            win_hi        = '0;
            taken         = '0;
            errors        = 0;
        endfunction

        function void set_window_length(logic [LEN_W-1:0] len);
            window_length = len;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Fold one sample into the window; close it when full
        function void note_sample(logic [SAMPLE_BITS-1:0] s);
            int unsigned            span;
            int unsigned            amp;
            int unsigned            peak;
            int unsigned            lvl;
            logic [SAMPLE_BITS-1:0] diff;
            meter_reading_t         rd;
            span = (window_length == '0) ? 32'd1 : 32'(window_length);
            if (s < win_lo) win_lo = s;
            if (s > win_hi) win_hi = s;
            taken = taken + 1'b1;
            if (taken < span && taken != 0) return;

            diff = win_hi - win_lo;
            amp  = 32'(diff);
            peak = 32'(peak_ref);
            if (amp > peak) peak = amp;
            else peak = (peak * DECAY_KEEP + amp) >> DECAY_SHIFT;
            if (peak < REF_FLOOR) peak = 32'(REF_FLOOR);
            peak_ref = SAMPLE_BITS'(peak);

            lvl = (amp * FULL_SCALE_PCT) / peak_ref;
            if (lvl > FULL_SCALE_PCT) lvl = 32'(FULL_SCALE_PCT);

            rd.level = LVL_W'(lvl);
            rd.amp   = diff;
            rd.peak  = peak_ref;
            expected_readings.push_back(rd);

            win_lo = '1;
            win_hi = '0;
            taken  = '0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result beat with the oldest reading
        task check_result(logic [LVL_W-1:0] level, logic [AMP_W-1:0] amp,
                          logic [REF_W-1:0] peak);
            meter_reading_t rd;
            if (expected_readings.size() == 0) begin
                report($sformatf("result beat with none due: lvl %0d amp %0d ref %0d",
                                 level, amp, peak));
            end else begin
                rd = expected_readings.pop_front();
                if (level !== rd.level)
                    report($sformatf("level_percent %0d, want %0d", level, rd.level));
                if (amp !== rd.amp)
                    report($sformatf("amplitude %0d, want %0d", amp, rd.amp));
                if (peak !== rd.peak)
                    report($sformatf("reference %0d, want %0d", peak, rd.peak));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    alpm_sample_if sample_ch ();
    alpm_result_if result_ch ();
    alpm_cfg_if    cfg_ch ();

    level_meter_scoreboard meter_sb;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_cycles_req;
    int cycle_count;

    audio_level_percent_meter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Beat monitor on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                meter_sb.set_window_length(cfg_ch.window_length);
            if (sample_ch.valid && sample_ch.ready)
                meter_sb.note_sample(sample_ch.sample);
            if (result_ch.valid && result_ch.ready)
                meter_sb.check_result(result_ch.level_percent, result_ch.amplitude,
                                      result_ch.reference);
        end
    end

    // Result receiver: random back-pressure, or a long hold when asked
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles_req > 0) begin
                result_ch.ready <= 1'b0;
                repeat (hold_cycles_req) @(posedge i_clk);
                hold_cycles_req = 0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one sample beat, maybe after an idle gap
    task automatic offer_sample(input logic [SAMPLE_W-1:0] s);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    task automatic write_window_length(input logic [LEN_W-1:0] len);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.window_length <= len;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop sending, wait for every reading, then let the block settle
    task automatic wait_meter_idle();
        sample_ch.valid <= 1'b0;
        do @(posedge i_clk); while (meter_sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random segment: new window length, then a shaped sample stream
    task automatic run_random_segment(input int max_items, output int used);
        int               pick;
        int               spread;
        int               base;
        sample_shape_t    shape;
        logic [LEN_W-1:0] len;
        logic [SAMPLE_W-1:0] s;
        wait_meter_idle();
        pick = $urandom_range(0, 99);
        if (pick < 5)        len = '0;
        else if (pick < 30)  len = LEN_W'(1);
        else if (pick < 55)  len = LEN_W'($urandom_range(2, 4));
        else if (pick < 85)  len = LEN_W'($urandom_range(5, 16));
        else if (pick < 96)  len = WIN_LEN_RST;
        else                 len = '1;
        write_window_length(len);

        used = (len <= 16) ? $urandom_range(8, 40) : $urandom_range(30, 150);
        if (used > max_items) used = max_items;
        shape  = sample_shape_t'($urandom_range(0, 3));
        spread = $urandom_range(0, 40);
        base   = $urandom_range(0, 4095 - spread);

        for (int i = 0; i < used; i++) begin
            case (shape)
                FULL_SWING:   s = SAMPLE_W'($urandom_range(0, 4095));
                NARROW_BAND:  s = SAMPLE_W'(base + $urandom_range(0, spread));
                FLAT_LINE:    s = SAMPLE_W'(base);
                default:      s = $urandom_range(0, 1) ? '1 : '0;
            endcase
            // occasional stray sample
            if ($urandom_range(0, 9) == 0) s = SAMPLE_W'($urandom_range(0, 4095));
            offer_sample(s);
        end
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct, input int budget);
        int done;
        int used;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done = 0;
        while (done < budget) begin
            run_random_segment(budget - done, used);
            done += used;
        end
    endtask

    // Stimulus
    initial begin
        meter_sb = new();
        i_rst_n              <= 1'b0;
        sample_ch.valid      <= 1'b0;
        sample_ch.sample     <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.window_length <= '0;
        tx_idle_pct     = 29;
        rx_idle_pct     = 88;
        hold_cycles_req = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Partial window at the reset length
        offer_sample('0);
        offer_sample('1);
        offer_sample(12'd2048);
        wait_meter_idle();
        // Longest window, window carries on across the write
        write_window_length('1);
        offer_sample('1);
        offer_sample(12'd1);
        wait_meter_idle();
        // Length cut below the samples taken: next sample closes
        write_window_length(16'd2);
        offer_sample(12'd7);
        wait_meter_idle();
        // Zero length behaves as one
        write_window_length('0);
        offer_sample('1);
        offer_sample('0);
        wait_meter_idle();
        write_window_length(16'd1);
        offer_sample(12'd1234);
        wait_meter_idle();
        write_window_length(16'd2);
        offer_sample('0);
        offer_sample('0);
        offer_sample(12'd100);
        offer_sample(12'd120);
        wait_meter_idle();
        write_window_length(16'd3);
        offer_sample('1);
        offer_sample('0);
        offer_sample('1);
        offer_sample(12'd2047);
        offer_sample(12'd2048);
        offer_sample(12'd2046);

        run_random_phase(29, 88, 240);
        run_random_phase(88, 29, 240);

        // Receiver holds off while samples keep coming; long run of
        // one-sample windows also walks the reference down towards its floor
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_meter_idle();
        write_window_length(16'd1);
        hold_cycles_req = HOLD_CYCLES;
        for (int i = 0; i < 120; i++) offer_sample(SAMPLE_W'($urandom_range(0, 4095)));

        run_random_phase(0, 0, 150);

        wait_meter_idle();
        if (meter_sb.pending() != 0)
            meter_sb.report($sformatf("%0d readings never arrived", meter_sb.pending()));
        if (meter_sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
